// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/pfu_pkg.sv =====
package pfu_pkg;

	localparam int CFG_IW = 2;
	localparam int CFG_DW = 16;

	typedef enum logic [CFG_IW-1:0] {
		REG_DIRECTION = 2'd0,
		REG_WIDTH     = 2'd1,
		REG_HEIGHT    = 2'd2
	} cfg_reg_t;

	localparam logic DIR_FILTER   = 1'b0;
	localparam logic DIR_UNFILTER = 1'b1;

	typedef logic [31:0] pix_t;

	typedef struct packed {
		logic have_left;
		logic have_up;
		logic row_end;
		logic frame_end;
	} pos_t;

endpackage

// ===== design/pfu_channel.sv =====
module pfu_channel import pfu_pkg::*; (
	input  logic       dir,
	input  logic [7:0] x,
	input  logic [7:0] a,
	input  logic [7:0] b,
	input  logic [7:0] c,
	output logic [7:0] y,
	output logic [7:0] orig
);

	logic signed [10:0] p;
	logic signed [10:0] da;
	logic signed [10:0] db;
	logic signed [10:0] dc;
	logic [10:0] abs_a;
	logic [10:0] abs_b;
	logic [10:0] abs_c;
	logic [7:0] pred;

	always_comb begin
		p = $signed({3'b0, a}) + $signed({3'b0, b}) - $signed({3'b0, c});
		da = p - $signed({3'b0, a});
		db = p - $signed({3'b0, b});
		dc = p - $signed({3'b0, c});
		abs_a = (da < 0) ? 11'(-da) : 11'(da);
		abs_b = (db < 0) ? 11'(-db) : 11'(db);
		abs_c = (dc < 0) ? 11'(-dc) : 11'(dc);
		if (abs_a <= abs_b && abs_a <= abs_c) begin
			pred = a;
		end else if (abs_b <= abs_c) begin
			pred = b;
		end else begin
			pred = c;
		end
		y = (dir == DIR_UNFILTER) ? x + pred : x - pred;
		orig = (dir == DIR_UNFILTER) ? y : x;
	end

endmodule

// ===== design/pfu_line_store.sv =====
module pfu_line_store import pfu_pkg::*; #(
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output pix_t          rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  pix_t          wr_data
);

	pix_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// same-entry write in the read cycle is forwarded
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
		end
	end

endmodule

// ===== design/pfu_raster_ctr.sv =====
module pfu_raster_ctr import pfu_pkg::*; #(
	parameter int MAX_WIDTH = 4096,
	parameter int CW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic [12:0]   width_pixels,
	input  logic [15:0]   height_rows,
	output logic [CW-1:0] col,
	output pos_t          pos
);

	logic [CW-1:0] col_q;
	logic [15:0] row_q;
	logic [16:0] w_ext;
	logic [16:0] w_eff;
	logic [15:0] h_eff;
	logic last_col;
	logic last_row;

	always_comb begin
		w_ext = {4'b0, width_pixels};
		if (w_ext == 17'd0) begin
			w_eff = 17'd1;
		end else if (w_ext > 17'(MAX_WIDTH)) begin
			w_eff = 17'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		h_eff = (height_rows == 16'd0) ? 16'd1 : height_rows;
		last_col = 17'(col_q) >= (w_eff - 17'd1);
		last_row = row_q >= (h_eff - 16'd1);
		col = col_q;
		pos.have_left = (col_q != '0);
		pos.have_up = (row_q != 16'd0);
		pos.row_end = last_col;
		pos.frame_end = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= 16'd0;
		end else if (advance) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? 16'd0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// ===== design/paeth_filter_unfilter_rgba_unit.sv =====
// path: the item and its line store read are registered in the s1 registers, then
//   predicted into the output register; s1 holds while the output is stalled
// throughput: one item per cycle while out_stall is low, set by the line store read and
//   the left-pixel feedback through one predictor and add per channel
// reset: counters and neighbor registers clear, direction = unfilter, width = 1,
//   height = 1; the line store is not cleared and needs no clearing pass
`include "assert_macros.svh"

module paeth_filter_unfilter_rgba_unit import pfu_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_red,
	input  logic [7:0]        in_green,
	input  logic [7:0]        in_blue,
	input  logic [7:0]        in_alpha,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_red,
	output logic [7:0]        out_green,
	output logic [7:0]        out_blue,
	output logic [7:0]        out_alpha,
	output logic              row_end,
	output logic              frame_end
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic direction_q;
	logic [12:0] width_q;
	logic [15:0] height_q;

	logic accept;
	logic s1_fire;
	logic [CW-1:0] col;
	pos_t pos;

	logic valid_s1;
	pix_t x_s1;
	pos_t pos_s1;
	logic [CW-1:0] col_s1;

	pix_t stored;
	pix_t left_q;
	pix_t upleft_q;
	pix_t a_pix;
	pix_t b_pix;
	pix_t c_pix;
	pix_t y_pix;
	pix_t orig_pix;

	logic out_valid_q;
	pix_t out_pix_q;
	logic row_end_q;
	logic frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_UNFILTER;
			width_q <= 13'd1;
			height_q <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DIRECTION: direction_q <= cfg_data[0];
				REG_WIDTH:     width_q <= cfg_data[12:0];
				REG_HEIGHT:    height_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign s1_fire = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_fire;
	assign accept = in_valid && !in_stall;

	pfu_raster_ctr #(
		.MAX_WIDTH(MAX_WIDTH),
		.CW(CW)
	) u_ctr (
		.clk(clk),
		.arst_n(arst_n),
		.advance(accept),
		.width_pixels(width_q),
		.height_rows(height_q),
		.col(col),
		.pos(pos)
	);

	pfu_line_store #(
		.DEPTH(MAX_WIDTH),
		.AW(CW)
	) u_store (
		.clk(clk),
		.rd_en(accept),
		.rd_addr(col),
		.rd_data(stored),
		.wr_en(s1_fire),
		.wr_addr(col_s1),
		.wr_data(orig_pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= {in_alpha, in_blue, in_green, in_red};
			pos_s1 <= pos;
			col_s1 <= col;
		end
	end

	always_comb begin
		a_pix = pos_s1.have_left ? left_q : '0;
		b_pix = pos_s1.have_up ? stored : '0;
		c_pix = (pos_s1.have_left && pos_s1.have_up) ? upleft_q : '0;
	end

	for (genvar g = 0; g < 4; g++) begin : g_ch
		pfu_channel u_ch (
			.dir(direction_q),
			.x(x_s1[8*g +: 8]),
			.a(a_pix[8*g +: 8]),
			.b(b_pix[8*g +: 8]),
			.c(c_pix[8*g +: 8]),
			.y(y_pix[8*g +: 8]),
			.orig(orig_pix[8*g +: 8])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			upleft_q <= '0;
		end else if (s1_fire) begin
			left_q <= orig_pix;
			upleft_q <= stored;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_pix_q <= y_pix;
			row_end_q <= pos_s1.row_end;
			frame_end_q <= pos_s1.frame_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_red = out_pix_q[7:0];
	assign out_green = out_pix_q[15:8];
	assign out_blue = out_pix_q[23:16];
	assign out_alpha = out_pix_q[31:24];
	assign row_end = row_end_q;
	assign frame_end = frame_end_q;

	`ASSERT_IMPL(a_frame_ends_row, clk, arst_n, out_valid_q && frame_end_q, row_end_q)
	`ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !s1_fire, valid_s1 && $stable(x_s1))
	`ASSERT_NEXT(a_fire_to_out, clk, arst_n, s1_fire, out_valid_q)

endmodule
